FILE: sv/length_prefixed_frame_deframer_core_assert.svh
// assertion macros for the length prefixed frame deframer
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LPFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LPFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lpfd_pkg.sv
// shared types, constants and helpers of the length prefixed frame deframer
package lpfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] LEAD_FIRST_RST  = 8'd62;
  localparam logic [BYTE_W-1:0] LEAD_SECOND_RST = 8'd60;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd172;
  localparam logic [LEN_W-1:0]  OUT_CAP_RST     = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEAD = 2'd1,
    PH_LEN1 = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAD_FIRST  = 2'd0,
    REG_LEAD_SECOND = 2'd1,
    REG_MAX_PAYLOAD = 2'd2,
    REG_OUT_CAP     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lead_first;
    logic [BYTE_W-1:0] lead_second;
    logic [LEN_W-1:0]  max_payload;
    logic [LEN_W-1:0]  out_cap;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [BYTE_W-1:0] len_lo;
    logic [LEN_W-1:0]  remaining;
    logic [LEN_W-1:0]  delivered;
  } parse_state_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_t;

  function automatic logic is_lead(input logic [BYTE_W-1:0] b, input cfg_t cfg);
    return (b == cfg.lead_first) || (b == cfg.lead_second);
  endfunction

endpackage

FILE: sv/length_prefixed_frame_deframer_core.sv
// top level of the length prefixed frame deframer
//
// in_*  : one received link byte per word; the block hunts for a lead byte,
//         a 16-bit little-endian length and then the payload
// out_* : one payload byte per word, out_tlast on the final delivered byte
//         of a frame (frame end or output capacity reached)
// cfg_* : register writes (0 lead first, 1 lead second, 2 max payload,
//         3 output capacity), taken at any edge with cfg_we high
// path: an accepted byte is held in the input register, parsed from there,
//   and its result word is registered in the result register
// throughput: one byte per cycle while the output is not stalled; the header
//   check and the rescan of the two held length bytes fit in the single parse step
// reset clears the parser to hunting, empties both registers and restores
//   the register defaults
// when out_tready is low with a word waiting, the parse step holds and
//   in_tready drops once the input register is also full
`include "length_prefixed_frame_deframer_core_assert.svh"

module length_prefixed_frame_deframer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lpfd_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpfd_pkg::BYTE_W-1:0]         out_tdata,  // [7:0] payload_byte
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [lpfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lpfd_pkg::cfg_t               cfg_r;
  lpfd_pkg::parse_state_t       st_r;
  lpfd_pkg::parse_state_t       st_nxt;
  lpfd_pkg::result_t            res;
  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [lpfd_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                         out_valid_r;
  logic [lpfd_pkg::BYTE_W-1:0]  out_data_r;
  logic                         out_last_r;
  logic                         advance;

  assign advance      = !out_valid_r || out_tready;
  assign in_tready    = !s1_valid_r || advance;
  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_first  <= lpfd_pkg::LEAD_FIRST_RST;
      cfg_r.lead_second <= lpfd_pkg::LEAD_SECOND_RST;
      cfg_r.max_payload <= lpfd_pkg::MAX_PAYLOAD_RST;
      cfg_r.out_cap     <= lpfd_pkg::OUT_CAP_RST;
    end else if (cfg_we) begin
      unique case (lpfd_pkg::cfg_reg_t'(cfg_addr))
        lpfd_pkg::REG_LEAD_FIRST:  cfg_r.lead_first  <= cfg_wdata[lpfd_pkg::BYTE_W-1:0];
        lpfd_pkg::REG_LEAD_SECOND: cfg_r.lead_second <= cfg_wdata[lpfd_pkg::BYTE_W-1:0];
        lpfd_pkg::REG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_wdata[lpfd_pkg::LEN_W-1:0];
        lpfd_pkg::REG_OUT_CAP:     cfg_r.out_cap     <= cfg_wdata[lpfd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  lpfd_parse u_parse (
    .cfg     (cfg_r),
    .st      (st_r),
    .rx_byte (s1_byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= lpfd_pkg::PH_HUNT;
      st_r.len_lo    <= '0;
      st_r.remaining <= '0;
      st_r.delivered <= '0;
    end else if (s1_valid_r && advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && res.valid) begin
      out_data_r <= res.data;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `LPFD_ASSERT_IMP(a_data_has_remaining, st_r.phase == lpfd_pkg::PH_DATA, st_r.remaining != '0, "payload phase with nothing remaining")
  `LPFD_ASSERT_NXT(a_s1_holds_on_stall, s1_valid_r && !advance, s1_valid_r && $stable(s1_byte_r) && $stable(st_r), "input byte or state moved during stall")
  `LPFD_ASSERT_NXT(a_no_out_without_byte, !s1_valid_r && advance, !out_tvalid, "result word without a parsed byte")

endmodule

FILE: sv/lpfd_parse.sv
// header scan, resync and payload delivery for one byte
module lpfd_parse (
  input  lpfd_pkg::cfg_t              cfg,
  input  lpfd_pkg::parse_state_t      st,
  input  logic [lpfd_pkg::BYTE_W-1:0] rx_byte,
  output lpfd_pkg::parse_state_t      st_nxt,
  output lpfd_pkg::result_t           res
);

  logic                       lead_lo;
  logic                       lead_b;
  logic [lpfd_pkg::LEN_W-1:0] flen;
  logic                       room;
  logic                       rem_end;

  assign lead_lo = lpfd_pkg::is_lead(st.len_lo, cfg);
  assign lead_b  = lpfd_pkg::is_lead(rx_byte, cfg);
  assign flen    = {rx_byte, st.len_lo};
  assign room    = st.delivered < cfg.out_cap;
  assign rem_end = st.remaining <= lpfd_pkg::LEN_W'(1);

  // next state
  always_comb begin
    st_nxt = st;
    unique case (st.phase)
      lpfd_pkg::PH_HUNT: begin
        if (lead_b) begin
          st_nxt.phase = lpfd_pkg::PH_LEAD;
        end
      end
      lpfd_pkg::PH_LEAD: begin
        st_nxt.len_lo = rx_byte;
        st_nxt.phase  = lpfd_pkg::PH_LEN1;
      end
      lpfd_pkg::PH_LEN1: begin
        if ((flen == '0) || (flen > cfg.max_payload)) begin
          // drop the lead, rescan both length bytes
          if (lead_lo) begin
            st_nxt.len_lo = rx_byte;
            st_nxt.phase  = lpfd_pkg::PH_LEN1;
          end else if (lead_b) begin
            st_nxt.phase = lpfd_pkg::PH_LEAD;
          end else begin
            st_nxt.phase = lpfd_pkg::PH_HUNT;
          end
        end else begin
          st_nxt.phase     = lpfd_pkg::PH_DATA;
          st_nxt.remaining = flen;
          st_nxt.delivered = '0;
        end
      end
      lpfd_pkg::PH_DATA: begin
        if (room) begin
          st_nxt.delivered = st.delivered + lpfd_pkg::LEN_W'(1);
        end
        if (rem_end) begin
          st_nxt.remaining = '0;
          st_nxt.phase     = lpfd_pkg::PH_HUNT;
        end else begin
          st_nxt.remaining = st.remaining - lpfd_pkg::LEN_W'(1);
        end
      end
      default: st_nxt = st;
    endcase
  end

  // result
  always_comb begin
    res.valid = (st.phase == lpfd_pkg::PH_DATA) && room;
    res.data  = rx_byte;
    res.last  = rem_end || ((st.delivered + lpfd_pkg::LEN_W'(1)) == cfg.out_cap);
  end

endmodule

FILE: bench/tb.sv
// testbench for the length prefixed frame deframer core, checked against a built-in predictor
`timescale 1ns / 100ps

module tb;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_BYTES   = 120;

  typedef struct packed {
    logic [lpfd_pkg::BYTE_W-1:0] data;
    logic                        last;
  } payload_word_t;

  typedef logic [lpfd_pkg::BYTE_W-1:0] byte_list_t[$];

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [lpfd_pkg::BYTE_W-1:0]     in_tdata   = '0;    // [7:0] rx_byte
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lpfd_pkg::BYTE_W-1:0]     out_tdata;          // [7:0] payload_byte
  logic                            out_tlast;
  logic                            cfg_we     = 1'b0;
  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  // predicted parser state and register copy
  lpfd_pkg::cfg_t              regs;
  lpfd_pkg::phase_t            parse_ph;
  logic [lpfd_pkg::BYTE_W-1:0] len_lo;
  logic [lpfd_pkg::LEN_W-1:0]  left_count;
  logic [lpfd_pkg::LEN_W-1:0]  sent_count;
  payload_word_t               expected_payload[$];

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off    = 0;
  bit          steady      = 1'b0;

  length_prefixed_frame_deframer_core u_top (.*);

  always #5 clk = ~clk;

  function automatic void scan_header(input logic [lpfd_pkg::BYTE_W-1:0] b);
    if (parse_ph == lpfd_pkg::PH_HUNT) begin
      if (b == regs.lead_first || b == regs.lead_second) parse_ph = lpfd_pkg::PH_LEAD;
    end else if (parse_ph == lpfd_pkg::PH_LEAD) begin
      len_lo   = b;
      parse_ph = lpfd_pkg::PH_LEN1;
    end
  endfunction

  function automatic void deframe_byte(input logic [lpfd_pkg::BYTE_W-1:0] b);
    logic [lpfd_pkg::LEN_W-1:0]  flen;
    logic [lpfd_pkg::BYTE_W-1:0] lo;
    payload_word_t               w;
    case (parse_ph)
      lpfd_pkg::PH_HUNT, lpfd_pkg::PH_LEAD: scan_header(b);
      lpfd_pkg::PH_LEN1: begin
        lo   = len_lo;
        flen = {b, lo};
        if (flen == '0 || flen > regs.max_payload) begin
          // drop the lead only, rescan both length bytes
          parse_ph = lpfd_pkg::PH_HUNT;
          scan_header(lo);
          scan_header(b);
        end else begin
          parse_ph   = lpfd_pkg::PH_DATA;
          left_count = flen;
          sent_count = '0;
        end
      end
      default: begin
        if (sent_count < regs.out_cap) begin
          w.data = b;
          w.last = (left_count <= 16'd1) || (sent_count + 16'd1 == regs.out_cap);
          expected_payload.push_back(w);
          sent_count = sent_count + 16'd1;
        end
        if (left_count <= 16'd1) begin
          left_count = '0;
          parse_ph   = lpfd_pkg::PH_HUNT;
        end else begin
          left_count = left_count - 16'd1;
        end
      end
    endcase
  endfunction

  task automatic send_byte(input logic [lpfd_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
  endtask

  task automatic send_list(input byte_list_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_frame(input logic [lpfd_pkg::BYTE_W-1:0] lead,
                            input logic [lpfd_pkg::LEN_W-1:0] flen);
    send_byte(lead);
    send_byte(flen[7:0]);
    send_byte(flen[15:8]);
    repeat (flen) send_byte(8'($urandom));
  endtask

  // all words delivered and the input register parsed
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lpfd_pkg::cfg_reg_t r,
                           input logic [lpfd_pkg::CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      lpfd_pkg::REG_LEAD_FIRST:  regs.lead_first  = v[lpfd_pkg::BYTE_W-1:0];
      lpfd_pkg::REG_LEAD_SECOND: regs.lead_second = v[lpfd_pkg::BYTE_W-1:0];
      lpfd_pkg::REG_MAX_PAYLOAD: regs.max_payload = v;
      lpfd_pkg::REG_OUT_CAP:     regs.out_cap     = v;
    endcase
  endtask

  task automatic set_config(input logic [lpfd_pkg::BYTE_W-1:0] lf,
                            input logic [lpfd_pkg::BYTE_W-1:0] ls,
                            input logic [lpfd_pkg::LEN_W-1:0] maxp,
                            input logic [lpfd_pkg::LEN_W-1:0] cap);
    settle();
    // unused upper bits of the lead registers carry junk
    write_reg(lpfd_pkg::REG_LEAD_FIRST, {8'($urandom), lf});
    write_reg(lpfd_pkg::REG_LEAD_SECOND, {8'($urandom), ls});
    write_reg(lpfd_pkg::REG_MAX_PAYLOAD, maxp);
    write_reg(lpfd_pkg::REG_OUT_CAP, cap);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    // good one-byte frame, zero length, length above max
    send_list('{lpfd_pkg::LEAD_FIRST_RST, 8'h01, 8'h00, 8'hFF,
                lpfd_pkg::LEAD_SECOND_RST, 8'h00, 8'h00,
                lpfd_pkg::LEAD_FIRST_RST, 8'hAD, 8'h00});
  endtask

  task automatic test_header_resync();
    // held length bytes turn into leads, then capacity cuts the frame
    set_config(8'h00, 8'hFF, 16'd4, 16'd2);
    send_list('{8'hFF, 8'h00, 8'hFF, 8'h03, 8'h00, 8'h55, 8'hAA, 8'h12});
  endtask

  task automatic test_capacity_limits();
    set_config(8'h00, 8'hFF, 16'hFFFF, 16'd0);
    send_list('{8'hFF, 8'h02, 8'h00, 8'h11, 8'h22});
    set_config(8'h00, 8'hFF, 16'd0, 16'd1);
    send_list('{8'h00, 8'h01, 8'h00});
  endtask

  task automatic test_backpressure();
    set_config(lpfd_pkg::LEAD_FIRST_RST, lpfd_pkg::LEAD_SECOND_RST,
               lpfd_pkg::MAX_PAYLOAD_RST, lpfd_pkg::OUT_CAP_RST);
    steady = 1'b1;
    send_list('{8'h00, 8'h00});
    hold_off = 200;
    send_frame(lpfd_pkg::LEAD_FIRST_RST, 16'd100);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned                 count;
    int unsigned                 kind;
    int unsigned                 lim;
    int unsigned                 n;
    logic [lpfd_pkg::LEN_W-1:0]  flen;
    logic [lpfd_pkg::BYTE_W-1:0] lead;
    logic [lpfd_pkg::BYTE_W-1:0] lf;
    logic [lpfd_pkg::BYTE_W-1:0] ls;
    for (int p = 0; p < 6; p++) begin
      lf = 8'($urandom);
      ls = 8'($urandom);
      case (p)
        0: set_config(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        1: set_config(lf, lf, 16'($urandom_range(1, 40)), 16'($urandom_range(1, 6)));
        2: set_config(lf, ls, 16'd1, 16'd1);
        3: set_config(lf, ls, 16'($urandom_range(2, 300)), 16'hFFFF);
        default: set_config(lf, ls, 16'($urandom_range(1, 64)), 16'($urandom_range(1, 40)));
      endcase
      count = 0;
      while (count < PHASE_BYTES) begin
        if ($urandom_range(0, 15) == 0) steady = !steady;
        // widest lengths only with clean framing, no noise there
        kind = (p == 0) ? 0 : $urandom_range(0, 9);
        lead = ($urandom_range(0, 1) != 0) ? regs.lead_first : regs.lead_second;
        if (kind <= 6) begin
          lim = (regs.max_payload < 24) ? regs.max_payload : 24;
          if ($urandom_range(0, 15) == 0) lim = (regs.max_payload < 300) ? regs.max_payload : 300;
          flen = 16'($urandom_range(1, lim));
          send_frame(lead, flen);
          count += flen + 3;
        end else if (kind == 7) begin
          n = $urandom_range(1, 4);
          repeat (n) send_byte(8'($urandom));
          count += n;
        end else if (kind == 8) begin
          if (regs.max_payload == 16'hFFFF || $urandom_range(0, 1) != 0) flen = '0;
          else flen = 16'($urandom_range(regs.max_payload + 1, 65535));
          send_byte(lead);
          send_byte(flen[7:0]);
          send_byte(flen[15:8]);
          count += 3;
        end else begin
          // header cut after the low length byte
          send_byte(lead);
          send_byte(8'($urandom));
          count += 2;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin : payload_sink
    payload_word_t want;
    int unsigned   stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (expected_payload.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: data %h last %b", out_tdata, out_tlast);
        end else begin
          want = expected_payload.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected data %h last %b, got data %h last %b",
                       want.data, want.last, out_tdata, out_tlast);
          end
        end
        stall = steady ? 0 : $urandom_range(0, 3);
      end
      if (hold_off != 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    regs.lead_first  = lpfd_pkg::LEAD_FIRST_RST;
    regs.lead_second = lpfd_pkg::LEAD_SECOND_RST;
    regs.max_payload = lpfd_pkg::MAX_PAYLOAD_RST;
    regs.out_cap     = lpfd_pkg::OUT_CAP_RST;
    parse_ph   = lpfd_pkg::PH_HUNT;
    len_lo     = '0;
    left_count = '0;
    sent_count = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_header_resync();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();
    settle();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
